[hw/rtl/drabt_pkg.sv]
// Package for the dual-rate alpha-beta tracker: register codes, reset values,
// micro-op types, the microcode ROM and the 32-bit saturation helper.
// No dependencies.
package drabt_pkg;

	localparam int AXES = 3;
	localparam int DW   = 32;  // Q16.16 data width
	localparam int GW   = 16;  // Q0.16 gain width
	localparam int PW   = 48;  // kept bits of gain * value
	localparam int UAW  = 4;   // microcode address width

	typedef enum logic [1:0] {
		REG_ALPHA   = 2'd0,
		REG_BETA_XY = 2'd1,
		REG_BETA_Z  = 2'd2,
		REG_DT      = 2'd3
	} reg_idx_t;

	localparam logic [GW-1:0] ALPHA_RST   = 16'd18442;
	localparam logic [GW-1:0] BETA_XY_RST = 16'd2559;
	localparam logic [GW-1:0] BETA_Z_RST  = 16'd1707;
	localparam logic [GW-1:0] DT_RST      = 16'd3277;

	typedef enum logic [1:0] {
		GAIN_ALPHA = 2'd0,
		GAIN_BETA  = 2'd1,
		GAIN_DT    = 2'd2
	} gain_sel_t;

	typedef enum logic {
		SRC_INNOV = 1'b0,
		SRC_VEL   = 1'b1
	} mul_src_t;

	typedef enum logic {
		DST_POS = 1'b0,
		DST_VEL = 1'b1
	} acc_dst_t;

	// One control word per microcode step
	typedef struct packed {
		logic           innov_en;  // form innovation for mul_axis
		logic           mul_en;    // load product register
		gain_sel_t      gain;
		mul_src_t       src;
		logic [1:0]     mul_axis;
		logic           acc_en;    // add rounded product into dst[acc_axis]
		acc_dst_t       dst;
		logic [1:0]     acc_axis;
		logic           out_en;    // load result register (may stall)
		logic           jmp_op;    // jump to jmp_tgt when item is a prediction tick
		logic [UAW-1:0] jmp_tgt;
		logic           last;      // final step of the item
	} ucw_t;

	localparam logic [UAW-1:0] UA_REPORT = 4'd10;

	function automatic ucw_t ucode_rom(input logic [UAW-1:0] addr);
		ucw_t w;
		w = '0;
		case (addr)
			4'd0: begin
				w.innov_en = 1'b1; w.mul_axis = 2'd0;
				w.jmp_op = 1'b1; w.jmp_tgt = UA_REPORT;
			end
			4'd1: begin
				w.mul_en = 1'b1; w.gain = GAIN_ALPHA; w.src = SRC_INNOV; w.mul_axis = 2'd0;
			end
			4'd2: begin
				w.mul_en = 1'b1; w.gain = GAIN_BETA; w.src = SRC_INNOV; w.mul_axis = 2'd0;
				w.acc_en = 1'b1; w.dst = DST_POS; w.acc_axis = 2'd0;
			end
			4'd3: begin
				w.acc_en = 1'b1; w.dst = DST_VEL; w.acc_axis = 2'd0;
				w.innov_en = 1'b1; w.mul_axis = 2'd1;
			end
			4'd4: begin
				w.mul_en = 1'b1; w.gain = GAIN_ALPHA; w.src = SRC_INNOV; w.mul_axis = 2'd1;
			end
			4'd5: begin
				w.mul_en = 1'b1; w.gain = GAIN_BETA; w.src = SRC_INNOV; w.mul_axis = 2'd1;
				w.acc_en = 1'b1; w.dst = DST_POS; w.acc_axis = 2'd1;
			end
			4'd6: begin
				w.acc_en = 1'b1; w.dst = DST_VEL; w.acc_axis = 2'd1;
				w.innov_en = 1'b1; w.mul_axis = 2'd2;
			end
			4'd7: begin
				w.mul_en = 1'b1; w.gain = GAIN_ALPHA; w.src = SRC_INNOV; w.mul_axis = 2'd2;
			end
			4'd8: begin
				w.mul_en = 1'b1; w.gain = GAIN_BETA; w.src = SRC_INNOV; w.mul_axis = 2'd2;
				w.acc_en = 1'b1; w.dst = DST_POS; w.acc_axis = 2'd2;
			end
			4'd9: begin
				w.acc_en = 1'b1; w.dst = DST_VEL; w.acc_axis = 2'd2;
			end
			4'd10: begin
				w.out_en = 1'b1;
				w.mul_en = 1'b1; w.gain = GAIN_DT; w.src = SRC_VEL; w.mul_axis = 2'd0;
			end
			4'd11: begin
				w.mul_en = 1'b1; w.gain = GAIN_DT; w.src = SRC_VEL; w.mul_axis = 2'd1;
				w.acc_en = 1'b1; w.dst = DST_POS; w.acc_axis = 2'd0;
			end
			4'd12: begin
				w.mul_en = 1'b1; w.gain = GAIN_DT; w.src = SRC_VEL; w.mul_axis = 2'd2;
				w.acc_en = 1'b1; w.dst = DST_POS; w.acc_axis = 2'd1;
			end
			4'd13: begin
				w.acc_en = 1'b1; w.dst = DST_POS; w.acc_axis = 2'd2;
				w.last = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

	// Clamp a 34-bit exact sum to the signed 32-bit range
	function automatic logic [DW-1:0] sat32(input logic [DW+1:0] v);
		if ((v[DW+1:DW-1] == 3'b000) || (v[DW+1:DW-1] == 3'b111))
			return v[DW-1:0];
		else if (v[DW+1])
			return {1'b1, {(DW-1){1'b0}}};
		else
			return {1'b0, {(DW-1){1'b1}}};
	endfunction

endpackage

[hw/rtl/dual_rate_alpha_beta_tracker_top.sv]
// Top level of the three-axis alpha-beta tracker: microcode sequencer and
// a shared gain multiplier datapath. Depends on drabt_pkg.
//
// Results: a result is loaded into the result register at the report step, which a
//   measurement reaches after updating all three axes and a prediction tick by a jump.
// Input beats: a new beat is taken only alongside the final step of the current one;
//   the single 17x32 multiplier steps through the axes under the microcode program
//   (one step per cycle while the report step is not held by back-pressure).
// Reset: arst_n clears gains to their defaults and the position and velocity
//   estimates to zero; the block is ready in the first cycle after release.
module dual_rate_alpha_beta_tracker_top
	import drabt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	// configuration write port
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [15:0]   cfg_wdata,
	// input beats
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [191:0]  s_tdata,   // meas_x, meas_y, meas_z, ref_x, ref_y, ref_z
	input  logic [0:0]    s_tuser,   // op
	// result beats
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [191:0]  m_tdata    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
);

	// configuration registers
	logic [GW-1:0] alpha_q, beta_xy_q, beta_z_q, dt_q;

	// captured input beat
	logic          op_q;
	logic [DW-1:0] meas_q [AXES];
	logic [DW-1:0] ref_q  [AXES];

	// tracker state
	logic [DW-1:0] pos_q [AXES];
	logic [DW-1:0] vel_q [AXES];

	// sequencer
	logic           busy_q;
	logic [UAW-1:0] pc_q;
	ucw_t           cw;
	logic           stall;
	logic           advance;
	logic           s_fire;

	// datapath
	logic [DW-1:0]        innov_q;
	logic [PW-1:0]        prod_q;
	logic [GW-1:0]        gain;
	logic [DW-1:0]        mul_op;
	logic signed [PW:0]   mul_full;
	logic [DW+1:0]        innov_sum;
	logic [DW-1:0]        acc_old;
	logic [DW+1:0]        acc_sum;

	logic           m_tvalid_q;
	logic [191:0]   m_tdata_q;

	assign cw = ucode_rom(pc_q);

	// Hold the report step while the previous result is still unclaimed
	assign stall   = cw.out_en & m_tvalid_q & ~m_tready;
	assign advance = busy_q & ~stall;

	// Take a new beat when idle, or alongside the final step of the current one
	assign s_tready = ~busy_q | cw.last;
	assign s_fire   = s_tvalid & s_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= ALPHA_RST;
			beta_xy_q <= BETA_XY_RST;
			beta_z_q  <= BETA_Z_RST;
			dt_q      <= DT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_ALPHA:   alpha_q   <= cfg_wdata;
				REG_BETA_XY: beta_xy_q <= cfg_wdata;
				REG_BETA_Z:  beta_z_q  <= cfg_wdata;
				REG_DT:      dt_q      <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	// capture the input beat; payload needs no reset
	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_q <= s_tuser[0];
			for (int a = 0; a < AXES; a++) begin
				meas_q[a] <= s_tdata[a*DW +: DW];
				ref_q[a]  <= s_tdata[(AXES+a)*DW +: DW];
			end
		end
	end

	// step counter with the conditional jump on prediction ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (s_fire) begin
			busy_q <= 1'b1;
			pc_q   <= '0;
		end else if (advance) begin
			if (cw.last) begin
				busy_q <= 1'b0;
				pc_q   <= '0;
			end else if (cw.jmp_op && op_q) begin
				pc_q <= cw.jmp_tgt;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	// innovation: meas - ref - pos, exact then clamped
	assign innov_sum = {{2{meas_q[cw.mul_axis][DW-1]}}, meas_q[cw.mul_axis]}
		- {{2{ref_q[cw.mul_axis][DW-1]}}, ref_q[cw.mul_axis]}
		- {{2{pos_q[cw.mul_axis][DW-1]}}, pos_q[cw.mul_axis]};

	// gain and operand select for the shared multiplier
	always_comb begin
		case (cw.gain)
			GAIN_ALPHA: gain = alpha_q;
			GAIN_BETA:  gain = (cw.mul_axis == 2'd2) ? beta_z_q : beta_xy_q;
			GAIN_DT:    gain = dt_q;
			default:    gain = alpha_q;
		endcase
		mul_op = (cw.src == SRC_VEL) ? vel_q[cw.mul_axis] : innov_q;
	end

	assign mul_full = $signed({1'b0, gain}) * $signed(mul_op);

	// accumulate: old + floor(p / 2^16) + bit 15 of p rounds half towards +inf
	assign acc_old = (cw.dst == DST_VEL) ? vel_q[cw.acc_axis] : pos_q[cw.acc_axis];
	assign acc_sum = {{2{acc_old[DW-1]}}, acc_old}
		+ {{2{prod_q[PW-1]}}, prod_q[PW-1:16]}
		+ {{(DW+1){1'b0}}, prod_q[15]};

	always_ff @(posedge clk) begin
		if (advance && cw.innov_en)
			innov_q <= sat32(innov_sum);
		if (advance && cw.mul_en)
			prod_q <= mul_full[PW-1:0];
	end

	// estimate registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				pos_q[a] <= '0;
				vel_q[a] <= '0;
			end
		end else if (advance && cw.acc_en) begin
			if (cw.dst == DST_VEL)
				vel_q[cw.acc_axis] <= sat32(acc_sum);
			else
				pos_q[cw.acc_axis] <= sat32(acc_sum);
		end
	end

	// result register: loaded at the report step, before propagation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && cw.out_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cw.out_en) begin
			for (int a = 0; a < AXES; a++) begin
				m_tdata_q[a*DW +: DW]        <= pos_q[a];
				m_tdata_q[(AXES+a)*DW +: DW] <= vel_q[a];
			end
		end
	end

	// an accepted beat always starts the program at step zero
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (busy_q && pc_q == '0))
		else $error("sequencer did not start at step zero");

	// a result appears only after a report step was executed
	a_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(busy_q && cw.out_en && !stall))
		else $error("result raised outside the report step");

	// the final step ends the item unless a new beat was taken with it
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cw.last && !s_fire) |=> !busy_q)
		else $error("sequencer ran past its final step");

	// the x-axis estimates are not written while the report step is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && stall) |=> ($stable(pos_q[0]) && $stable(vel_q[0])))
		else $error("estimate changed during a held report");

endmodule

[test/tb_top.sv]
// Self-checking bench for the three-axis alpha-beta tracker: directed table, then
// randomised phases under varying gains and back-pressure, scored against a predictor.
// Depends on drabt_pkg and dual_rate_alpha_beta_tracker_top.
module tb_top;
	import drabt_pkg::*;

	// Kind of step carried in s_tuser
	typedef enum bit {
		OP_MEASURE = 1'b0,
		OP_PREDICT = 1'b1
	} op_t;

	// Six 32-bit lanes: in = meas_x..z, ref_x..z; out = pos_x..z, vel_x..z
	typedef logic [5:0][31:0] word6_t;

	typedef struct {
		bit        is_cfg;
		reg_idx_t  idx;
		logic [15:0] val;
		op_t       op;
		word6_t    data;
		bit        typed;  // expected beat written out in the table
		word6_t    want;
	} stim_row_t;

	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam int SETTLE_CYCLES  = 16;      // result beat leaves before propagation ends
	localparam int CYCLE_LIMIT    = 400000;
	localparam int PHASES         = 8;
	localparam int PHASE_BEATS    = 175;
	localparam int PRINT_CAP      = 30;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_idx;
	logic [15:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;   // meas_x, meas_y, meas_z, ref_x, ref_y, ref_z
	logic [0:0]   s_tuser;   // op
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z

	dual_rate_alpha_beta_tracker_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Tracker state and gains as the predictor sees them
	logic [31:0] est_pos [3];
	logic [31:0] est_vel [3];
	logic [15:0] gain_alpha, gain_beta_xy, gain_beta_z, gain_dt;

	word6_t      pending_tracks [$];  // estimates still owed by the block, oldest first
	stim_row_t   plan [$];
	word6_t      owed;
	string       lane_name [6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

	int unsigned cycle_count;
	int          mismatch_count;
	int          beats_sent, measure_beats, predict_beats, results_checked, settings_applied;
	int          src_pct, sink_pct;  // idle odds per cycle, in percent

	// Clock: period of 2
	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic longint widen(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	// Clamp an exact sum to the signed 32-bit range
	function automatic logic [31:0] clamp_q16(longint v);
		if (v > 64'sd2147483647)
			return Q_MAX;
		if (v < -64'sd2147483648)
			return Q_MIN;
		return v[31:0];
	endfunction

	// Q0.16 gain times Q16.16 value, rounded half up to Q16.16
	function automatic longint scale_round(logic [15:0] g, longint v);
		longint p;
		p = longint'({48'd0, g}) * v;
		return (p + 64'sd32768) >>> 16;
	endfunction

	// Fold one input beat into the estimate; return the beat it reports
	function automatic word6_t track_advance(op_t op, word6_t d);
		word6_t      r;
		longint      innov;
		logic [15:0] beta;
		if (op == OP_MEASURE) begin
			for (int i = 0; i < 3; i++) begin
				innov = widen(clamp_q16(widen(d[i]) - widen(d[3+i]) - widen(est_pos[i])));
				beta = (i == 2) ? gain_beta_z : gain_beta_xy;
				est_pos[i] = clamp_q16(widen(est_pos[i]) + scale_round(gain_alpha, innov));
				est_vel[i] = clamp_q16(widen(est_vel[i]) + scale_round(beta, innov));
			end
		end
		for (int i = 0; i < 3; i++) begin
			r[i]   = est_pos[i];
			r[3+i] = est_vel[i];
		end
		// coast position by one time step
		for (int i = 0; i < 3; i++)
			est_pos[i] = clamp_q16(widen(est_pos[i]) + scale_round(gain_dt, widen(est_vel[i])));
		return r;
	endfunction

	function automatic logic [15:0] reset_gain(reg_idx_t idx);
		case (idx)
			REG_ALPHA:   return ALPHA_RST;
			REG_BETA_XY: return BETA_XY_RST;
			REG_BETA_Z:  return BETA_Z_RST;
			default:     return DT_RST;
		endcase
	endfunction

	// Extremes, the reset value or anything in between
	function automatic logic [15:0] pick_gain(reg_idx_t idx);
		case ($urandom_range(3))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return reset_gain(idx);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic word6_t pack_axes(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
			logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
		return {rz, ry, rx, mz, my, mx};
	endfunction

	// Mostly a plausible track with small offsets; now and then raw noise and extremes
	function automatic word6_t random_sample();
		word6_t d;
		bit     noisy;
		noisy = ($urandom_range(4) == 0);
		for (int i = 0; i < 6; i++) begin
			if (noisy) begin
				case ($urandom_range(5))
					0:       d[i] = Q_MIN;
					1:       d[i] = Q_MAX;
					2:       d[i] = 32'h0000_0000;
					3:       d[i] = 32'hFFFF_FFFF;
					default: d[i] = $urandom;
				endcase
			end else if (i < 3) begin
				d[i] = $urandom_range(32'h7F_FFFF) - 32'h40_0000;
			end else begin
				d[i] = $urandom_range(32'h1_FFFF) - 32'h1_0000;
			end
		end
		return d;
	endfunction

	function automatic void plan_item(op_t op, word6_t data, bit typed, word6_t want);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.idx    = REG_ALPHA;
		r.val    = '0;
		r.op     = op;
		r.data   = data;
		r.typed  = typed;
		r.want   = want;
		plan.push_back(r);
	endfunction

	function automatic void plan_cfg(reg_idx_t idx, logic [15:0] val);
		stim_row_t r;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.val    = val;
		r.op     = OP_MEASURE;
		r.data   = '0;
		r.typed  = 1'b0;
		r.want   = '0;
		plan.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("cycle %0d: %s got %h want %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Present the write until it has been sampled; the caller drops cfg_we after the last one
	task automatic write_reg(reg_idx_t idx, logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		case (idx)
			REG_ALPHA:   gain_alpha   = v;
			REG_BETA_XY: gain_beta_xy = v;
			REG_BETA_Z:  gain_beta_z  = v;
			default:     gain_dt      = v;
		endcase
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed beat is out and propagation has finished
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (pending_tracks.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic source_gap();
		while ($urandom_range(99) < src_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
	endtask

	// Present one beat until it is taken; log what the block owes for it
	task automatic send_beat(op_t op, word6_t data, bit typed, word6_t want);
		word6_t predicted;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = track_advance(op, data);
		pending_tracks.push_back(typed ? want : predicted);
		beats_sent++;
		if (op == OP_MEASURE)
			measure_beats++;
		else
			predict_beats++;
		@(negedge clk);
	endtask

	// Receiver: stall at random while the phase asks for it
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_pct);
	end

	// ------------------------------------------------------------------
	// Checking: compare every result beat with the oldest owed estimate
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_tracks.size() == 0) begin
				report_mismatch("result beat with nothing owed, pos_x", m_tdata[31:0], '0);
			end else begin
				owed = pending_tracks.pop_front();
				for (int i = 0; i < 6; i++)
					if (m_tdata[32*i +: 32] !== owed[i])
						report_mismatch(lane_name[i], m_tdata[32*i +: 32], owed[i]);
				results_checked++;
			end
		end
	end

	// Watchdog: end the run if the block hangs
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d beats still owed", cycle_count,
			pending_tracks.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		stim_row_t row;
		op_t       op;
		int        n;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_idx     = '0;
		cfg_wdata   = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		m_tready    = 1'b0;
		cycle_count = 0;
		src_pct     = 0;
		sink_pct    = 0;
		for (int i = 0; i < 3; i++) begin
			est_pos[i] = '0;
			est_vel[i] = '0;
		end
		gain_alpha   = ALPHA_RST;
		gain_beta_xy = BETA_XY_RST;
		gain_beta_z  = BETA_Z_RST;
		gain_dt      = DT_RST;

		// Directed table. A tick straight after reset reports zeros whatever
		// the measurement lanes hold; a measurement equal to its offset leaves
		// a zero state at zero.
		plan_item(OP_PREDICT, pack_axes(32'hA5A5_A5A5, Q_MAX, Q_MIN,
			32'h5A5A_5A5A, Q_MIN, Q_MAX), 1'b1, '0);
		plan_item(OP_MEASURE, pack_axes(32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
			32'h1234_5678, 32'h1234_5678, 32'h1234_5678), 1'b1, '0);
		// innovation overflow both ways
		plan_item(OP_MEASURE, pack_axes(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN), 1'b0, '0);
		plan_item(OP_PREDICT, '0, 1'b0, '0);
		plan_item(OP_MEASURE, pack_axes(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX), 1'b0, '0);
		plan_item(OP_MEASURE, pack_axes(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h1, 32'h1, 32'h1), 1'b0, '0);
		plan_item(OP_PREDICT, '1, 1'b0, '0);
		// full gains: drive positions and velocities into saturation
		plan_cfg(REG_ALPHA, 16'hFFFF);
		plan_cfg(REG_BETA_XY, 16'hFFFF);
		plan_cfg(REG_BETA_Z, 16'hFFFF);
		plan_cfg(REG_DT, 16'hFFFF);
		repeat (4) plan_item(OP_MEASURE, pack_axes(Q_MAX, Q_MAX, Q_MAX, '0, '0, '0), 1'b0, '0);
		repeat (2) plan_item(OP_PREDICT, '0, 1'b0, '0);
		repeat (3) plan_item(OP_MEASURE, pack_axes(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX),
			1'b0, '0);
		plan_item(OP_PREDICT, '0, 1'b0, '0);
		// zero gains: the estimate must not move
		plan_cfg(REG_ALPHA, 16'h0000);
		plan_cfg(REG_BETA_XY, 16'h0000);
		plan_cfg(REG_BETA_Z, 16'h0000);
		plan_cfg(REG_DT, 16'h0000);
		plan_item(OP_MEASURE, pack_axes(32'h0001_0000, 32'hFFFF_0000, 32'h7000_0000,
			32'h0, 32'h0, 32'h0), 1'b0, '0);
		plan_item(OP_PREDICT, '0, 1'b0, '0);
		// half-way products: check rounding of positive and negative halves
		plan_cfg(REG_ALPHA, 16'h8000);
		plan_cfg(REG_BETA_XY, 16'h0001);
		plan_cfg(REG_BETA_Z, 16'h8000);
		plan_cfg(REG_DT, 16'h0001);
		plan_item(OP_MEASURE, pack_axes(32'h0000_8001, 32'h0000_0001, 32'h0000_0003,
			'0, '0, '0), 1'b0, '0);
		plan_item(OP_MEASURE, pack_axes(32'hFFFF_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFD,
			'0, '0, '0), 1'b0, '0);
		plan_item(OP_PREDICT, '0, 1'b0, '0);

		// Hold reset, then release it between edges
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the table; group register writes and keep them clear of traffic
		for (n = 0; n < plan.size(); n++) begin
			row = plan[n];
			if (row.is_cfg) begin
				if (n == 0 || !plan[n-1].is_cfg) begin
					drain_block();
					settings_applied++;
				end
				write_reg(row.idx, row.val);
				if (n + 1 == plan.size() || !plan[n+1].is_cfg)
					cfg_we <= 1'b0;
			end else begin
				send_beat(row.op, row.data, row.typed, row.want);
			end
		end

		// Random phases: each writes a gain set (defaults first, random picks after) and takes one of four idling patterns
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_block();
			case (phase % 4)
				0: begin src_pct = 0;  sink_pct = 0;  end
				1: begin src_pct = 59; sink_pct = 0;  end
				2: begin src_pct = 0;  sink_pct = 59; end
				default: begin src_pct = 24; sink_pct = 24; end
			endcase
			for (int k = 0; k < 4; k++)
				write_reg(reg_idx_t'(k), (phase == 0) ? reset_gain(reg_idx_t'(k))
					: pick_gain(reg_idx_t'(k)));
			cfg_we <= 1'b0;
			settings_applied++;
			for (n = 0; n < PHASE_BEATS; n++) begin
				// halfway through, hold the source until the block has caught up
				if (n == PHASE_BEATS / 2)
					drain_block();
				source_gap();
				op = ($urandom_range(9) < 7) ? OP_MEASURE : OP_PREDICT;
				send_beat(op, random_sample(), 1'b0, '0);
			end
		end

		drain_block();
		$display("%0d beats in (%0d measurements, %0d ticks) across %0d gain sets;",
			beats_sent, measure_beats, predict_beats, settings_applied);
		$display("%0d result beats scored, %0d mismatching lanes", results_checked,
			mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
